// ----- hdl/stbl_pkg.sv -----
package stbl_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] value;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_value;
		logic [5:0]  found_position;
	} rsp_t;

endpackage

// ----- hdl/stbl_req_if.sv -----
interface stbl_req_if;
	logic          valid;
	logic          ready;
	stbl_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/stbl_rsp_if.sv -----
interface stbl_rsp_if;
	logic          valid;
	logic          ready;
	stbl_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/stbl_ram.sv -----
module stbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/sorted_table_engine_unit.sv -----
// Sorted table of signed 32-bit values held in one single-port-read RAM of
// CAPACITY words. One transaction is taken at a time. Full, empty and bad
// position answers and the removal of the last entry go straight to the
// result. A read fetches the entry at its position. Search walks the RAM one
// entry a cycle from position 0 and stops at a match, at the first entry
// above the value or at the end of the table. Insert scans to its slot s the
// same way and then moves each later entry up by one, each move a read and a
// write. Insert into an empty table writes entry 0 directly. Remove at
// position p moves the tail down one entry a cycle. The result sits in an
// output register. The next transaction is taken the cycle after that result
// has been delivered.
module sorted_table_engine_unit #(
	parameter int CAPACITY = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	stbl_req_if.sink   req,
	stbl_rsp_if.source rsp
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;

	stbl_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [1:0]    act_q, act_d;
	logic [31:0]   val_q, val_d;
	logic [31:0]   carry_q, carry_d;
	logic          pend_q, pend_d;
	stbl_pkg::rsp_t out_q, out_d;
	logic          ovalid_q, ovalid_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	stbl_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign req.ready   = (state_q == stbl_pkg::S_IDLE) && !ovalid_q;
	assign rsp.valid   = ovalid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stbl_pkg::S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ovalid_q <= ovalid_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		act_q   <= act_d;
		val_q   <= val_d;
		carry_q <= carry_d;
		out_q   <= out_d;
	end

	always_comb begin
		logic [PW-1:0] pos_ext;
		logic [CW-1:0] nxt;
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		act_d    = act_q;
		val_d    = val_q;
		carry_d  = carry_q;
		pend_d   = 1'b0;
		out_d    = out_q;
		ovalid_d = ovalid_q && !rsp.ready;
		we       = 1'b0;
		waddr    = idx_q[AW-1:0];
		wdata    = carry_q;
		raddr    = idx_q[AW-1:0];
		pos_ext  = PW'(req.payload.position);
		nxt      = idx_q + 1'b1;
		case (state_q)
			stbl_pkg::S_IDLE: begin
				if (req.valid && !ovalid_q) begin
					act_d = req.payload.action;
					val_d = req.payload.value;
					out_d = '0;
					state_d = stbl_pkg::S_DONE;
					case (req.payload.action)
						stbl_pkg::ACT_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								out_d.status = stbl_pkg::ST_FULL;
							end else if (count_q == '0) begin
								idx_d = '0;
								carry_d = req.payload.value;
								state_d = stbl_pkg::S_SHIFT_UP;
							end else begin
								idx_d = '0;
								raddr = '0;
								pend_d = 1'b1;
								state_d = stbl_pkg::S_SCAN;
							end
						end
						stbl_pkg::ACT_SEARCH: begin
							if (count_q == '0) begin
								out_d.status = stbl_pkg::ST_EMPTY;
							end else begin
								idx_d = '0;
								raddr = '0;
								pend_d = 1'b1;
								state_d = stbl_pkg::S_SCAN;
							end
						end
						default: begin
							if (count_q == '0) begin
								out_d.status = stbl_pkg::ST_EMPTY;
							end else if (pos_ext >= PW'(count_q)) begin
								out_d.status = stbl_pkg::ST_BADPOS;
							end else begin
								idx_d = CW'(pos_ext);
								raddr = AW'(pos_ext);
								pend_d = 1'b1;
								state_d = (req.payload.action == stbl_pkg::ACT_READ) ?
									stbl_pkg::S_READ : stbl_pkg::S_SHIFT_DN;
								if (req.payload.action == stbl_pkg::ACT_REMOVE) begin
									// read the entry above the removed one
									idx_d = CW'(pos_ext + 1'b1);
									raddr = AW'(pos_ext + 1'b1);
									pend_d = (pos_ext + 1'b1) < PW'(count_q);
									if (!((pos_ext + 1'b1) < PW'(count_q))) begin
										count_d = count_q - 1'b1;
										state_d = stbl_pkg::S_DONE;
									end
								end
							end
						end
					endcase
				end
			end
			stbl_pkg::S_READ: begin
				out_d.found_value = rdata;
				state_d = stbl_pkg::S_DONE;
			end
			stbl_pkg::S_SCAN: begin
				// rdata holds entry idx_q
				if (act_q == stbl_pkg::ACT_SEARCH) begin
					if ($signed(rdata) == $signed(val_q)) begin
						out_d.found_position = 6'(idx_q);
						state_d = stbl_pkg::S_DONE;
					end else if ($signed(rdata) > $signed(val_q) || nxt >= count_q) begin
						out_d.status = stbl_pkg::ST_NOTFOUND;
						state_d = stbl_pkg::S_DONE;
					end else begin
						idx_d = nxt;
						raddr = AW'(nxt);
						pend_d = 1'b1;
					end
				end else begin
					// slot 0 if below entry 0, else first j>=1 with entry >= value
					if ((idx_q == '0 && $signed(val_q) < $signed(rdata)) ||
					    (idx_q != '0 && $signed(rdata) >= $signed(val_q))) begin
						carry_d = val_q;
						state_d = stbl_pkg::S_SHIFT_UP;
					end else if (nxt >= count_q) begin
						idx_d = nxt;
						carry_d = val_q;
						state_d = stbl_pkg::S_SHIFT_UP;
					end else begin
						idx_d = nxt;
						raddr = AW'(nxt);
						pend_d = 1'b1;
					end
				end
			end
			stbl_pkg::S_SHIFT_UP: begin
				// write carry at idx, carry the old entry (in rdata) upward
				if (!pend_q && idx_q < count_q) begin
					raddr = idx_q[AW-1:0];
					pend_d = 1'b1;
				end else begin
					we = 1'b1;
					if (idx_q >= count_q) begin
						count_d = count_q + 1'b1;
						state_d = stbl_pkg::S_DONE;
					end else begin
						carry_d = rdata;
						idx_d = nxt;
					end
				end
			end
			stbl_pkg::S_SHIFT_DN: begin
				// rdata holds entry idx_q; move it to idx_q-1
				we = 1'b1;
				waddr = AW'(idx_q - 1'b1);
				wdata = rdata;
				if (nxt >= count_q) begin
					count_d = count_q - 1'b1;
					state_d = stbl_pkg::S_DONE;
				end else begin
					idx_d = nxt;
					raddr = AW'(nxt);
					pend_d = 1'b1;
				end
			end
			stbl_pkg::S_DONE: begin
				ovalid_d = 1'b1;
				state_d = stbl_pkg::S_IDLE;
			end
			default: state_d = stbl_pkg::S_IDLE;
		endcase
	end
endmodule

// ----- hdl/stbl_checker.sv -----
module stbl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input stbl_pkg::rsp_t rsp_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.status <= stbl_pkg::ST_FULL)
		else $error("status code out of range");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("transaction taken while result pending");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != stbl_pkg::ST_OK |->
		rsp_payload.found_value == '0 && rsp_payload.found_position == '0)
		else $error("nonzero result fields on failed transaction");
endmodule

bind sorted_table_engine_unit stbl_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);
